// ===== rtl/fsil_pkg.sv =====
// ----------------------------------------------------------------------------
// fsil_pkg - shared types for the finger sorted insert list
// codes, field widths and the control and link structs between top and cells
// ----------------------------------------------------------------------------
`default_nettype none

package fsil_pkg;

    localparam int MODE_BITS   = 2;
    localparam int KEY_BITS    = 32;
    localparam int STATUS_BITS = 2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DRAIN  = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_DRAINED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // what every cell does at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } t_cell_op;

    // new key against the key under the cursor
    typedef enum logic [1:0] {
        CMP_LT,
        CMP_EQ,
        CMP_GT
    } t_cmp;

    typedef struct packed {
        t_cell_op                   op;
        t_cmp                       cmp;
        logic signed [KEY_BITS-1:0] key;
    } t_cell_ctrl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic signed [KEY_BITS-1:0] key;
        logic                       valid;
        logic                       eq;
        logic                       after;
    } t_link;

endpackage

`default_nettype wire

// ===== rtl/fsil_cell.sv =====
// ----------------------------------------------------------------------------
// fsil_cell - one slot of the sorted list
// holds a key, a tag, an occupied flag and the cursor flag; decides locally
// whether its entry lands after a new key and moves toward its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module fsil_cell
    import fsil_pkg::*;
#(
    parameter int TAG_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire logic [TAG_BITS-1:0] i_new_tag,
    input  wire logic                i_past_cur,
    input  wire t_link               i_left,
    input  wire logic [TAG_BITS-1:0] i_left_tag,
    input  wire t_link               i_right,
    input  wire logic [TAG_BITS-1:0] i_right_tag,
    output t_link                    o_link,
    output logic [TAG_BITS-1:0]      o_tag,
    output logic                     o_cur
);

    logic signed [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0]        r_tag;
    logic                       r_valid;
    logic                       r_cur;

    logic w_gt;
    logic w_eq;
    logic w_goes_after;

    always_comb begin
        w_gt = r_valid && (r_key > i_ctrl.key);
        w_eq = r_valid && (r_key == i_ctrl.key);
        case (i_ctrl.cmp)
            // walking left: equal keys stay in front
            CMP_LT:  w_goes_after = w_gt;
            // walking right: only the first equal key stays in front
            CMP_GT:  w_goes_after = w_gt || (w_eq && i_left.eq);
            // same key as cursor: everything past the cursor moves
            CMP_EQ:  w_goes_after = w_gt || (w_eq && i_past_cur);
            default: w_goes_after = w_gt;
        endcase
    end

    assign o_link.key   = r_key;
    assign o_link.valid = r_valid;
    assign o_link.eq    = w_eq;
    assign o_link.after = w_goes_after || !r_valid;
    assign o_tag        = r_tag;
    assign o_cur        = r_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cur   <= 1'b0;
        end else begin
            case (i_ctrl.op)
                CELL_INSERT: begin
                    if (i_left.after) begin
                        r_key   <= i_left.key;
                        r_tag   <= i_left_tag;
                        r_valid <= i_left.valid;
                        r_cur   <= 1'b0;
                    end else if (o_link.after) begin
                        r_key   <= i_ctrl.key;
                        r_tag   <= i_new_tag;
                        r_valid <= 1'b1;
                        r_cur   <= 1'b1;
                    end else begin
                        r_cur   <= 1'b0;
                    end
                end
                CELL_SHIFT: begin
                    r_key   <= i_right.key;
                    r_tag   <= i_right_tag;
                    r_valid <= i_right.valid;
                    r_cur   <= 1'b0;
                end
                CELL_CLEAR: begin
                    r_valid <= 1'b0;
                    r_cur   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/finger_sorted_insert_list.sv =====
// ----------------------------------------------------------------------------
// finger_sorted_insert_list - ascending key list with an insertion cursor
// a row of cells keeps the list in order; the top level runs the requests
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request: tdata = mode, insert_key, insert_tag from
//   bit 0 up. mode insert places the entry by a search from the cursor,
//   drain reads the list out in ascending order and empties it, clear
//   empties it. m_axis carries results: tdata = status, out_key, out_tag,
//   tlast marks the final result of a request.
//   insert, clear and the unused mode give one result: accepted at an edge,
//   the result shows on m_axis after that edge. a drain of N entries gives
//   N results, one per cycle when the receiver keeps up, since the cell row
//   shifts one entry toward the head per result; no request is taken until
//   the entry marked tlast has been loaded.
//   the single output register sets the rate: a new request is taken in
//   the cycle its result register frees up, so back-to-back inserts run
//   at one per cycle while m_axis_tready stays high.
//   a stall on m_axis holds the result and blocks s_axis_tready; a drain
//   in progress pauses without losing or repeating an entry.
//   reset (synchronous, active low) empties the list, clears the cursor and
//   drops any pending result; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module finger_sorted_insert_list
    import fsil_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // mode, insert_key, insert_tag (from bit 0 up)
    input  wire logic [((MODE_BITS+KEY_BITS+TAG_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // status, out_key, out_tag (from bit 0 up)
    output logic [((STATUS_BITS+KEY_BITS+TAG_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic               m_axis_tlast
);

    localparam int IN_KEY_LO  = MODE_BITS;
    localparam int IN_TAG_LO  = MODE_BITS + KEY_BITS;
    localparam int OUT_KEY_LO = STATUS_BITS;
    localparam int OUT_TAG_LO = STATUS_BITS + KEY_BITS;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    logic                       r_o_valid;
    logic                       n_o_valid;
    t_status                    r_o_status;
    t_status                    n_o_status;
    logic signed [KEY_BITS-1:0] r_o_key;
    logic signed [KEY_BITS-1:0] n_o_key;
    logic [TAG_BITS-1:0]        r_o_tag;
    logic [TAG_BITS-1:0]        n_o_tag;
    logic                       r_o_last;
    logic                       n_o_last;

    logic [MODE_BITS-1:0]       w_mode;
    logic signed [KEY_BITS-1:0] w_key;
    logic [TAG_BITS-1:0]        w_tag;
    logic                       w_out_free;
    logic                       w_accept;
    t_cell_op                   w_op;
    t_cell_ctrl                 w_ctrl;
    logic signed [KEY_BITS-1:0] w_cur_key;
    logic [DEPTH-1:0]           w_cur_vec;
    logic [DEPTH-1:0]           w_past_cur;

    t_link                      w_link      [DEPTH];
    logic [TAG_BITS-1:0]        w_tags      [DEPTH];
    t_link                      w_left      [DEPTH];
    logic [TAG_BITS-1:0]        w_left_tag  [DEPTH];
    t_link                      w_right     [DEPTH];
    logic [TAG_BITS-1:0]        w_right_tag [DEPTH];

    assign w_mode = s_axis_tdata[MODE_BITS-1:0];
    assign w_key  = signed'(s_axis_tdata[IN_KEY_LO +: KEY_BITS]);
    assign w_tag  = s_axis_tdata[IN_TAG_LO +: TAG_BITS];

    assign w_out_free    = !r_o_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // key under the cursor; at most one cell holds the cursor
    always_comb begin
        w_cur_key = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_cur_vec[i]) begin
                w_cur_key = w_cur_key | w_link[i].key;
            end
        end
    end

    // cells strictly to the right of the cursor
    assign w_past_cur = ~((w_cur_vec << 1) - DEPTH'(1));

    always_comb begin
        w_ctrl.op  = w_op;
        w_ctrl.key = w_key;
        if (w_key < w_cur_key) begin
            w_ctrl.cmp = CMP_LT;
        end else if (w_key > w_cur_key) begin
            w_ctrl.cmp = CMP_GT;
        end else begin
            w_ctrl.cmp = CMP_EQ;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign w_left[i]     = '0;
            assign w_left_tag[i] = '0;
        end else begin : g_mid
            assign w_left[i]     = w_link[i-1];
            assign w_left_tag[i] = w_tags[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign w_right[i]     = '0;
            assign w_right_tag[i] = '0;
        end else begin : g_body
            assign w_right[i]     = w_link[i+1];
            assign w_right_tag[i] = w_tags[i+1];
        end

        fsil_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_new_tag   (w_tag),
            .i_past_cur  (w_past_cur[i]),
            .i_left      (w_left[i]),
            .i_left_tag  (w_left_tag[i]),
            .i_right     (w_right[i]),
            .i_right_tag (w_right_tag[i]),
            .o_link      (w_link[i]),
            .o_tag       (w_tags[i]),
            .o_cur       (w_cur_vec[i])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_o_valid  = r_o_valid && !m_axis_tready;
        n_o_status = r_o_status;
        n_o_key    = r_o_key;
        n_o_tag    = r_o_tag;
        n_o_last   = r_o_last;
        w_op       = CELL_HOLD;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_ACCEPTED;
                    n_o_key    = '0;
                    n_o_tag    = '0;
                    n_o_last   = 1'b1;
                    case (w_mode)
                        MODE_INSERT: begin
                            if (w_link[DEPTH-1].valid) begin
                                n_o_status = ST_DROPPED;
                            end else begin
                                w_op = CELL_INSERT;
                            end
                        end
                        MODE_DRAIN: begin
                            if (w_link[0].valid) begin
                                // results come from the drain state
                                n_o_valid = 1'b0;
                                n_state   = S_DRAIN;
                            end else begin
                                n_o_status = ST_EMPTY;
                            end
                        end
                        MODE_CLEAR: begin
                            w_op = CELL_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_DRAINED;
                    n_o_key    = w_link[0].key;
                    n_o_tag    = w_tags[0];
                    n_o_last   = !w_link[1].valid;
                    w_op       = CELL_SHIFT;
                    if (!w_link[1].valid) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_o_status <= n_o_status;
        r_o_key    <= n_o_key;
        r_o_tag    <= n_o_tag;
        r_o_last   <= n_o_last;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = r_o_last;

    always_comb begin
        m_axis_tdata                           = '0;
        m_axis_tdata[STATUS_BITS-1:0]          = r_o_status;
        m_axis_tdata[OUT_KEY_LO +: KEY_BITS]   = r_o_key;
        m_axis_tdata[OUT_TAG_LO +: TAG_BITS]   = r_o_tag;
    end

endmodule

`default_nettype wire

// ===== rtl/fsil_check.sv =====
// ----------------------------------------------------------------------------
// fsil_check - port-level checks for the finger sorted insert list
// watches both stream groups and is bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fsil_check
    import fsil_pkg::*;
#(
    parameter int TAG_BITS = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [((STATUS_BITS+KEY_BITS+TAG_BITS+7)/8)*8-1:0] m_axis_tdata,
    input wire logic m_axis_tlast
);

    localparam int OUT_KEY_LO = STATUS_BITS;
    localparam int OUT_TAG_LO = STATUS_BITS + KEY_BITS;

    logic w_drained;

    assign w_drained = (m_axis_tdata[STATUS_BITS-1:0] == ST_DRAINED);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // only drain results can be followed by more results of one request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_drained) |-> m_axis_tlast)
        else $error("non-drain result without tlast");

    // key and tag fields are zero outside drained entries
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_drained) |->
            (m_axis_tdata[OUT_KEY_LO +: KEY_BITS] == '0) &&
            (m_axis_tdata[OUT_TAG_LO +: TAG_BITS] == '0))
        else $error("payload on a status-only result");

    // no request taken while a drain run is still open
    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_drained && !m_axis_tlast) |-> !s_axis_tready)
        else $error("request taken in the middle of a drain");

endmodule

bind finger_sorted_insert_list fsil_check #(
    .TAG_BITS (TAG_BITS)
) u_fsil_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/tb_finger_sorted_insert_list.sv =====
// ----------------------------------------------------------------------------
// tb_finger_sorted_insert_list - self-checking bench for the sorted insert list
// a queue of requests feeds a stream driver; a monitor predicts every result
// from its own copy of the list and cursor and checks each one field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_finger_sorted_insert_list;
    import fsil_pkg::*;

    localparam int DEPTH        = 64;
    localparam int TAG_BITS     = 16;
    localparam int IN_W         = ((MODE_BITS + KEY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((STATUS_BITS + KEY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 155;
    localparam int IDLE_PCT     = 14;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [MODE_BITS-1:0]       mode;
        logic signed [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0]        tag;
        bit                         wait_drain;
    } t_request;

    typedef struct {
        t_status                    status;
        logic signed [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0]        tag;
        logic                       last;
    } t_result;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    wire              s_axis_tready;
    // mode, insert_key, insert_tag (from bit 0 up)
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // status, out_key, out_tag (from bit 0 up)
    wire [OUT_W-1:0]  m_axis_tdata;
    wire              m_axis_tlast;

    finger_sorted_insert_list #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predicted list state
    logic signed [KEY_BITS-1:0] list_keys [DEPTH];
    logic [TAG_BITS-1:0]        list_tags [DEPTH];
    int unsigned                list_count  = 0;
    int unsigned                list_cursor = 0;

    t_request pending[$];
    t_result  due_results[$];
    t_request cur_req;
    bit       req_taken      = 1'b0;
    int       errors         = 0;
    int       total_requests = 0;
    int       accepted_count = 0;
    int       result_count   = 0;
    int       drop_count     = 0;
    int       drained_count  = 0;

    function automatic void add_request(logic [MODE_BITS-1:0] mode,
                                        logic signed [KEY_BITS-1:0] key,
                                        logic [TAG_BITS-1:0] tag, bit wait_drain);
        t_request rq;
        rq.mode       = mode;
        rq.key        = key;
        rq.tag        = tag;
        rq.wait_drain = wait_drain;
        pending.push_back(rq);
    endfunction

    // 0 narrow range with many duplicates, 1 full range, 2 near the extremes
    function automatic logic signed [KEY_BITS-1:0] pick_key(int kind);
        logic signed [KEY_BITS-1:0] k;
        case (kind)
            0: begin
                k = $urandom_range(8);
                k = k - 4;
            end
            1: k = $urandom;
            default: begin
                if ($urandom_range(1))
                    k = 32'h7fff_ffff - $urandom_range(3);
                else
                    k = 32'h8000_0000 + $urandom_range(3);
            end
        endcase
        return k;
    endfunction

    function automatic void push_result(t_status status, logic signed [KEY_BITS-1:0] key,
                                        logic [TAG_BITS-1:0] tag, logic last);
        t_result r;
        r.status = status;
        r.key    = key;
        r.tag    = tag;
        r.last   = last;
        due_results.push_back(r);
    endfunction

    // walk from the cursor to the position the new key takes
    function automatic int unsigned locate_slot(logic signed [KEY_BITS-1:0] key);
        int unsigned                j;
        logic signed [KEY_BITS-1:0] ck;
        if (list_count == 0)
            return 0;
        j = list_cursor;
        if (j >= list_count)
            j = list_count - 1;
        ck = list_keys[j];
        if (key < ck) begin
            while (j > 0) begin
                j--;
                if (list_keys[j] <= key)
                    break;
            end
        end else if (key > ck) begin
            while (j + 1 < list_count) begin
                j++;
                if (key <= list_keys[j])
                    break;
            end
        end
        return (key < list_keys[j]) ? j : j + 1;
    endfunction

    function automatic void apply_list_request(t_request rq);
        int unsigned p;
        int          i;
        case (rq.mode)
            MODE_INSERT: begin
                if (list_count >= DEPTH) begin
                    drop_count++;
                    push_result(ST_DROPPED, '0, '0, 1'b1);
                end else begin
                    p = locate_slot(rq.key);
                    for (i = list_count; i > p; i--) begin
                        list_keys[i] = list_keys[i-1];
                        list_tags[i] = list_tags[i-1];
                    end
                    list_keys[p] = rq.key;
                    list_tags[p] = rq.tag;
                    list_count++;
                    list_cursor = p;
                    push_result(ST_ACCEPTED, '0, '0, 1'b1);
                end
            end
            MODE_DRAIN: begin
                if (list_count == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (i = 0; i < list_count; i++)
                        push_result(ST_DRAINED, list_keys[i], list_tags[i],
                                    (i + 1 == list_count));
                    drained_count += list_count;
                    list_count  = 0;
                    list_cursor = 0;
                end
            end
            MODE_CLEAR: begin
                list_count  = 0;
                list_cursor = 0;
                push_result(ST_ACCEPTED, '0, '0, 1'b1);
            end
            default: push_result(ST_ACCEPTED, '0, '0, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [KEY_BITS-1:0] got,
                                   logic [KEY_BITS-1:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 result_count, what, got, want);
        errors++;
    endtask

    // both sides run without gaps for a stretch in the middle of the run
    function automatic bit calm_window();
        return accepted_count >= 80 && accepted_count < 130;
    endfunction

    // request driver
    always @(negedge i_clk) begin : drive_proc
        t_request        rq;
        logic            nxt_valid;
        logic [IN_W-1:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (i_rst_n && (req_taken || !s_axis_tvalid)) begin
            nxt_valid = 1'b0;
            if (pending.size() > 0) begin
                rq = pending[0];
                if (rq.wait_drain && due_results.size() > 0) begin
                    // hold off until every due result is out
                end else if (!calm_window() && $urandom_range(99) < IDLE_PCT) begin
                    // random gap
                end else begin
                    void'(pending.pop_front());
                    cur_req   = rq;
                    nxt_valid = 1'b1;
                    nxt_data  = '0;
                    nxt_data[0 +: MODE_BITS]                  = rq.mode;
                    nxt_data[MODE_BITS +: KEY_BITS]           = rq.key;
                    nxt_data[MODE_BITS + KEY_BITS +: TAG_BITS] = rq.tag;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // result sink
    always @(negedge i_clk) begin : sink_proc
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm_window() || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: check results first, then predict for a new request
    always @(posedge i_clk) begin : monitor_proc
        t_result want;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing due",
                                    m_axis_tdata[STATUS_BITS +: KEY_BITS], '0);
                end else begin
                    want = due_results.pop_front();
                    if (m_axis_tdata[0 +: STATUS_BITS] !== want.status)
                        report_mismatch("status",
                                        KEY_BITS'(m_axis_tdata[0 +: STATUS_BITS]),
                                        KEY_BITS'(want.status));
                    if (m_axis_tdata[STATUS_BITS +: KEY_BITS] !== want.key)
                        report_mismatch("out_key", m_axis_tdata[STATUS_BITS +: KEY_BITS],
                                        want.key);
                    if (m_axis_tdata[STATUS_BITS + KEY_BITS +: TAG_BITS] !== want.tag)
                        report_mismatch("out_tag",
                                        KEY_BITS'(m_axis_tdata[STATUS_BITS + KEY_BITS +:
                                                               TAG_BITS]),
                                        KEY_BITS'(want.tag));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", KEY_BITS'(m_axis_tlast),
                                        KEY_BITS'(want.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req_taken = 1'b1;
                accepted_count++;
                apply_list_request(cur_req);
            end
        end
    end

    initial begin : stimulus_proc
        int n;
        int i;
        int len;
        int kind;
        int pick;
        bit full_done;
        logic signed [KEY_BITS-1:0] k;

        // directed part
        add_request(MODE_DRAIN,  '0, '0, 1'b0);               // drain on empty list
        add_request(MODE_UNUSED, '0, '0, 1'b0);
        add_request(MODE_CLEAR,  '0, '0, 1'b0);
        add_request(MODE_INSERT, 32'sd0, 16'h0000, 1'b0);     // insert into empty list
        add_request(MODE_INSERT, 32'h7fff_ffff, 16'hffff, 1'b0);
        add_request(MODE_INSERT, 32'h8000_0000, 16'h1234, 1'b0);
        add_request(MODE_INSERT, 32'sd0, 16'h0001, 1'b0);     // walks right onto an equal key
        add_request(MODE_INSERT, 32'sd0, 16'h0002, 1'b0);     // equal to the cursor
        add_request(MODE_INSERT, -32'sd5, 16'h0003, 1'b0);    // walks left
        add_request(MODE_INSERT, 32'sd7, 16'h0004, 1'b0);     // walks right to a larger one
        add_request(MODE_INSERT, 32'h7fff_ffff, 16'h8000, 1'b0);
        add_request(MODE_INSERT, 32'h8000_0000, 16'h5a5a, 1'b0);
        add_request(MODE_UNUSED, 32'hffff_ffff, 16'hffff, 1'b0);
        add_request(MODE_DRAIN,  '0, '0, 1'b1);
        add_request(MODE_DRAIN,  '0, '0, 1'b0);
        add_request(MODE_INSERT, 32'sd42, 16'h00aa, 1'b0);
        add_request(MODE_CLEAR,  32'hdead_beef, 16'hbeef, 1'b0);
        add_request(MODE_DRAIN,  '0, '0, 1'b0);
        add_request(MODE_INSERT, 32'sd3, 16'h0030, 1'b0);
        add_request(MODE_INSERT, 32'sd1, 16'h0010, 1'b0);
        add_request(MODE_INSERT, 32'sd2, 16'h0020, 1'b0);
        add_request(MODE_DRAIN,  '0, '0, 1'b0);

        // random part: mostly insert runs closed by a drain
        n = 0;
        full_done = 1'b0;
        while (n < RANDOM_ITEMS) begin
            if (!full_done && n >= 60) begin
                // fill past capacity so that inserts get dropped, then drain it all
                add_request(MODE_CLEAR, $urandom, TAG_BITS'($urandom), 1'b0);
                for (i = 0; i < DEPTH + 3; i++) begin
                    k = $urandom_range(40);
                    k = k - 20;
                    if ($urandom_range(7) == 0)
                        k = pick_key($urandom_range(1, 2));
                    add_request(MODE_INSERT, k, TAG_BITS'($urandom), 1'b0);
                end
                add_request(MODE_DRAIN, $urandom, TAG_BITS'($urandom), 1'b1);
                n += DEPTH + 5;
                full_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(30, 16)
                                                : $urandom_range(12, 1);
                kind = $urandom_range(2);
                for (i = 0; i < len; i++)
                    add_request(MODE_INSERT,
                                pick_key(($urandom_range(4) == 0) ? $urandom_range(2) : kind),
                                TAG_BITS'($urandom), 1'b0);
                add_request(MODE_DRAIN, $urandom, TAG_BITS'($urandom),
                            $urandom_range(4) == 0);
                n += len + 1;
            end else if (pick < 85) begin
                add_request(MODE_BITS'($urandom_range(3)), pick_key($urandom_range(2)),
                            TAG_BITS'($urandom), 1'b0);
                n++;
            end else begin
                // run broken off by a clear
                len = $urandom_range(6, 1);
                for (i = 0; i < len; i++)
                    add_request(MODE_INSERT, pick_key($urandom_range(2)),
                                TAG_BITS'($urandom), 1'b0);
                add_request(MODE_CLEAR, $urandom, TAG_BITS'($urandom), 1'b0);
                add_request(MODE_DRAIN, $urandom, TAG_BITS'($urandom), 1'b0);
                n += len + 2;
            end
        end
        total_requests = pending.size();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_requests)
            @(negedge i_clk);
        while (due_results.size() != 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        $display("ran %0d requests, checked %0d results", accepted_count, result_count);
        $display("%0d entries drained in order, %0d inserts dropped on a full list",
                 drained_count, drop_count);
        if (errors == 0 && due_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
